// File: design/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, format codes and the digit glyph table for the number to
// ASCII formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

	// Format selector codes
	localparam logic [1:0] FMT_HEX32 = 2'd0;
	localparam logic [1:0] FMT_HEX64 = 2'd1;
	localparam logic [1:0] FMT_DEC32 = 2'd2;

	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned BIN_W    = 32;            // bits converted in decimal mode
	localparam int unsigned BCD_DIGS = 10;            // decimal digits of a 32-bit value
	localparam int unsigned BCD_W    = 4 * BCD_DIGS;
	localparam int unsigned CNT_W    = 5;             // holds digit counts up to 16
	localparam int unsigned BITC_W   = $clog2(BIN_W);

	localparam logic [CNT_W-1:0] HEX32_DIGS = CNT_W'(8);
	localparam logic [CNT_W-1:0] HEX64_DIGS = CNT_W'(16);
	localparam logic [CNT_W-1:0] DEC32_DIGS = CNT_W'(BCD_DIGS);

	typedef struct packed {
		logic [1:0]         req_type;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} res_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic load_hex32;
		logic load_hex64;
		logic load_dec;
		logic dabble;     // one shift-add-3 step
		logic load_bcd;   // move BCD result into the output shifter
		logic shift;      // drop the top digit
	} cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic bits_last;  // final dabble step this cycle
		logic cnt_last;   // one digit left
		logic top_zero;   // top digit is zero
	} status_t;

	function automatic logic [7:0] glyph(input logic [3:0] nib);
		logic [7:0] ch;
		unique case (nib)
			4'h0: ch = 8'h30;
			4'h1: ch = 8'h31;
			4'h2: ch = 8'h32;
			4'h3: ch = 8'h33;
			4'h4: ch = 8'h34;
			4'h5: ch = 8'h35;
			4'h6: ch = 8'h36;
			4'h7: ch = 8'h37;
			4'h8: ch = 8'h38;
			4'h9: ch = 8'h39;
			4'hA: ch = 8'h41;
			4'hB: ch = 8'h42;
			4'hC: ch = 8'h43;
			4'hD: ch = 8'h44;
			4'hE: ch = 8'h45;
			default: ch = 8'h46;
		endcase
		return ch;
	endfunction

endpackage

// File: design/n2a_datapath.sv
// ----------------------------------------------------------------------------
// n2a_datapath
// Double-dabble binary to BCD converter and the digit output shifter.
// ----------------------------------------------------------------------------
module n2a_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  n2a_pkg::req_t   req,
	input  n2a_pkg::cmd_t   cmd,
	output n2a_pkg::status_t status,
	output n2a_pkg::res_t   result
);
	import n2a_pkg::*;

	logic [VALUE_W-1:0] sr_q;     // output digits, top nibble first
	logic [BIN_W-1:0]   bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BITC_W-1:0]  bitc_q;
	logic [BCD_W-1:0]   bcd_adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int d = 0; d < BCD_DIGS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5)
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			else
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hex32)
			sr_q <= {req.value[BIN_W-1:0], {(VALUE_W-BIN_W){1'b0}}};
		else if (cmd.load_hex64)
			sr_q <= req.value;
		else if (cmd.load_bcd)
			sr_q <= {bcd_q, {(VALUE_W-BCD_W){1'b0}}};
		else if (cmd.shift)
			sr_q <= {sr_q[VALUE_W-5:0], 4'h0};

		if (cmd.load_dec) begin
			bin_q <= req.value[BIN_W-1:0];
			bcd_q <= '0;
		end else if (cmd.dabble) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bitc_q <= '0;
		end else begin
			if (cmd.load_hex32)
				cnt_q <= HEX32_DIGS;
			else if (cmd.load_hex64)
				cnt_q <= HEX64_DIGS;
			else if (cmd.load_bcd)
				cnt_q <= DEC32_DIGS;
			else if (cmd.shift)
				cnt_q <= cnt_q - CNT_W'(1);

			if (cmd.load_dec)
				bitc_q <= '0;
			else if (cmd.dabble)
				bitc_q <= bitc_q + BITC_W'(1);
		end
	end

	assign status.bits_last = (bitc_q == BITC_W'(BIN_W-1));
	assign status.cnt_last  = (cnt_q == CNT_W'(1));
	assign status.top_zero  = (sr_q[VALUE_W-1 -: 4] == 4'h0);

	assign result.character = glyph(sr_q[VALUE_W-1 -: 4]);
	assign result.last      = status.cnt_last;

	// never shift out a digit that was not loaded
	a_shift_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> cnt_q != '0)
		else $error("digit shift with empty digit count");

endmodule

// File: design/n2a_ctrl.sv
// ----------------------------------------------------------------------------
// n2a_ctrl
// Sequencer: load, decimal conversion, leading-zero skip, digit emission.
// ----------------------------------------------------------------------------
module n2a_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       req_type,
	input  n2a_pkg::status_t status,
	output n2a_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             strobe
);
	import n2a_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DABBLE = 5'b00010,
		ST_LDBCD  = 5'b00100,
		ST_SKIP   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (req_type == FMT_HEX32) begin
						cmd.load_hex32 = 1'b1;
						state_d        = ST_EMIT;
					end else if (req_type == FMT_HEX64) begin
						cmd.load_hex64 = 1'b1;
						state_d        = ST_EMIT;
					end else if (req_type == FMT_DEC32) begin
						cmd.load_dec = 1'b1;
						state_d      = ST_DABBLE;
					end else begin
						state_d = ST_IDLE;   // unused selector: no output
					end
				end
			end
			ST_DABBLE: begin
				cmd.dabble = 1'b1;
				if (status.bits_last)
					state_d = ST_LDBCD;
			end
			ST_LDBCD: begin
				cmd.load_bcd = 1'b1;
				state_d      = ST_SKIP;
			end
			ST_SKIP: begin
				if (status.top_zero && !status.cnt_last)
					cmd.shift = 1'b1;
				else
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.shift = 1'b1;
				if (status.cnt_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = (state_q == ST_EMIT);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == FMT_HEX32 || req_type == FMT_HEX64 ||
			req_type == FMT_DEC32)) |=> busy)
		else $error("valid item accepted but block not busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status.cnt_last) |=> !busy)
		else $error("still busy after last character");

	a_emit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(strobe) && $past(state_q == ST_SKIP)) |->
			(!status.top_zero || status.cnt_last))
		else $error("decimal output starts with a leading zero");

endmodule

// File: design/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats one unsigned number as ASCII hex (32 or 64 bit) or decimal (32 bit).
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in an item (req.req_type, req.value).
// The characters then come out most significant first, one per cycle, each
// marked by a one-cycle strobe; the final one has result.last set. There is
// no back-pressure: the receiver must take a character in the cycle it is
// shown. Hex32 gives 8 characters and hex64 gives 16, starting the cycle
// after start. Decimal runs a bit-serial double-dabble conversion (32
// steps, one bit a cycle), moves the BCD word into the output shifter,
// drops leading zeros one digit a cycle, then emits the digits. Selector
// 3 is accepted and produces nothing. busy drops the cycle after the last
// character, and a new item may start then.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  n2a_pkg::req_t  req,
	output logic           strobe,
	output n2a_pkg::res_t  result
);
	import n2a_pkg::*;

	cmd_t    cmd;
	status_t status;

	// controller: sequencing only
	n2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.strobe   (strobe)
	);

	// datapath: BCD converter, digit shifter, counters
	n2a_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for number_to_ascii_formatter: directed corner values
// for every format, then random items of all four selectors under three
// sender idle profiles, each character checked against a local digit predictor.
// ----------------------------------------------------------------------------

// Keeps the characters still owed by the block, oldest first, and checks
// every character that comes out against them.
class digit_scoreboard;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;

	n2a_pkg::res_t owed_chars[$];
	int unsigned   fail_count;
	int unsigned   char_count;

	function new();
		fail_count = 0;
		char_count = 0;
	endfunction

	function logic [7:0] hex_glyph(input logic [3:0] nib);
		if (nib < 4'd10)
			return ASCII_ZERO + 8'(nib);
		return ASCII_UPPER_A + 8'(nib - 4'd10);
	endfunction

	// Work out the characters one accepted item owes and queue them.
	function void note_request(input n2a_pkg::req_t r);
		n2a_pkg::res_t   ch;
		logic [31:0]     v;
		logic [7:0]      dec_rev[10];
		int              ndig;
		case (r.req_type)
			n2a_pkg::FMT_HEX32, n2a_pkg::FMT_HEX64: begin
				ndig = (r.req_type == n2a_pkg::FMT_HEX64) ? 16 : 8;
				for (int k = ndig - 1; k >= 0; k--) begin
					ch.character = hex_glyph(r.value[4*k +: 4]);
					ch.last      = (k == 0);
					owed_chars.push_back(ch);
				end
			end
			n2a_pkg::FMT_DEC32: begin
				v    = r.value[31:0];
				ndig = 0;
				if (v == 32'd0) begin
					ch.character = ASCII_ZERO;
					ch.last      = 1'b1;
					owed_chars.push_back(ch);
				end else begin
					while (v != 32'd0) begin
						dec_rev[ndig] = ASCII_ZERO + 8'(v % 32'd10);
						ndig++;
						v = v / 32'd10;
					end
					for (int k = ndig - 1; k >= 0; k--) begin
						ch.character = dec_rev[k];
						ch.last      = (k == 0);
						owed_chars.push_back(ch);
					end
				end
			end
			default: ;  // unused selector owes nothing
		endcase
	endfunction

	function void check_character(input n2a_pkg::res_t got);
		n2a_pkg::res_t want;
		if (owed_chars.size() == 0) begin
			$error("unexpected character %h (last %b)", got.character, got.last);
			fail_count++;
			return;
		end
		want = owed_chars.pop_front();
		char_count++;
		if (got.character !== want.character) begin
			$error("character: expected %h, got %h", want.character, got.character);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %b, got %b", want.last, got.last);
			fail_count++;
		end
	endfunction

	function void flag_leftovers();
		if (owed_chars.size() != 0) begin
			$error("%0d characters never came out", owed_chars.size());
			fail_count++;
		end
	endfunction
endclass

module tb_top;
	import n2a_pkg::*;

	localparam logic [1:0] FMT_UNUSED = 2'd3;  // selector the block drops
	localparam int unsigned ITEMS_PER_PHASE = 84;
	localparam int unsigned MAX_GAP = 50;       // longest sender idle stretch
	localparam int unsigned DRAIN_LIMIT = 2000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  strobe;
	res_t  result;

	digit_scoreboard book = new();
	int unsigned     fmt_count[4];

	number_to_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run (~270 items).
	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	// Characters cannot be held off, so every strobe is checked right away.
	// Sampled at the rising edge, before the block updates its outputs.
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1)
			book.check_character(result);
	end

	// Present one item at the falling edge and hold it until the block
	// takes it (start high and busy low at a rising edge). start stays
	// high on return so back-to-back items need no extra toggling.
	task automatic send_item(input logic [1:0] fmt, input logic [63:0] val);
		@(negedge clk);
		start        = 1'b1;
		req.req_type = fmt;
		req.value    = val;
		do
			@(posedge clk);
		while (busy);
		book.note_request(req);
		fmt_count[fmt]++;
	endtask

	// Sender idle stretch; req carries junk so only start matters.
	task automatic sender_idle(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			start        = 1'b0;
			req.req_type = 2'($urandom);
			req.value    = {$urandom, $urandom};
		end
	endtask

	// Value mix: full-width noise, tiny low words, decimal numbers of a
	// chosen digit count, and single-bit / all-ones-but-one-bit patterns.
	function automatic logic [63:0] pick_value();
		longint unsigned lo, hi, span, p;
		int unsigned     ndig;
		logic [63:0]     v;
		case ($urandom_range(0, 4))
			0, 1: v = {$urandom, $urandom};
			2: v = {$urandom, 32'($urandom_range(0, 120))};
			3: begin
				ndig = $urandom_range(1, 10);
				p = 1;
				repeat (ndig - 1) p = p * 10;
				lo = (ndig == 1) ? 0 : p;
				hi = p * 10 - 1;
				if (hi > 64'hFFFF_FFFF)
					hi = 64'hFFFF_FFFF;
				span = hi - lo + 1;
				v = {$urandom, 32'(lo + ({$urandom, $urandom} % span))};
			end
			default: begin
				v = 64'd1 << $urandom_range(0, 63);
				if ($urandom_range(0, 1))
					v = ~v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [1:0] pick_format();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)      return FMT_HEX32;
		else if (r < 55) return FMT_HEX64;
		else if (r < 93) return FMT_DEC32;
		return FMT_UNUSED;
	endfunction

	task automatic random_phase(input int unsigned idle_pct);
		repeat (ITEMS_PER_PHASE) begin
			send_item(pick_format(), pick_value());
			if ($urandom_range(0, 99) < idle_pct)
				sender_idle($urandom_range(1, MAX_GAP));
		end
	endtask

	initial begin
		int unsigned waited;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		sender_idle(2);

		// --- directed part ---
		// hex32: extremes, digit walk, upper bits must not leak in
		send_item(FMT_HEX32, 64'h0);
		send_item(FMT_HEX32, 64'hFFFF_FFFF);
		send_item(FMT_HEX32, 64'h0123_4567_89AB_CDEF);
		send_item(FMT_HEX32, 64'hFFFF_FFFF_0000_0000);
		// hex64: extremes and every glyph in both orders
		send_item(FMT_HEX64, 64'h0);
		send_item(FMT_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FMT_HEX64, 64'h0123_4567_89AB_CDEF);
		send_item(FMT_HEX64, 64'hFEDC_BA98_7654_3210);
		// dec32: zero alone, zero with upper bits set, digit-count edges
		send_item(FMT_DEC32, 64'd0);
		send_item(FMT_DEC32, 64'hFFFF_FFFF_0000_0000);
		send_item(FMT_DEC32, 64'd1);
		send_item(FMT_DEC32, 64'd9);
		send_item(FMT_DEC32, 64'd10);
		send_item(FMT_DEC32, 64'd999_999_999);
		send_item(FMT_DEC32, 64'd1_000_000_000);
		send_item(FMT_DEC32, 64'hFFFF_FFFF);
		send_item(FMT_DEC32, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FMT_DEC32, 64'hA5A5_A5A5_0000_3039);
		// unused selector: must produce nothing, then a normal item follows
		send_item(FMT_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(FMT_UNUSED, 64'h0);
		send_item(FMT_HEX32, 64'h8000_0001);
		sender_idle(3);

		// --- random part, three sender profiles ---
		random_phase(15);
		random_phase(75);
		random_phase(0);

		// Drain: wait for owed characters, then a full decimal latency more
		// so any stray extra character is caught.
		sender_idle(1);
		waited = 0;
		while (book.owed_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		book.flag_leftovers();

		$display("covered %0d hex32, %0d hex64, %0d dec32, %0d unused-selector items",
			fmt_count[FMT_HEX32], fmt_count[FMT_HEX64], fmt_count[FMT_DEC32],
			fmt_count[FMT_UNUSED]);
		$display("%0d characters checked, %0d failures", book.char_count, book.fail_count);
		if (book.fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: number_to_ascii_formatter.f
design/n2a_pkg.sv
design/n2a_datapath.sv
design/n2a_ctrl.sv
design/number_to_ascii_formatter.sv
sim/tb_top.sv
